/* hdl/mi3_pkg.sv */
// Package with the request and result types of the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;

  localparam int unsigned Dim = 3;

  typedef struct packed {
    logic signed [15:0] a00;
    logic signed [15:0] a01;
    logic signed [15:0] a02;
    logic signed [15:0] a10;
    logic signed [15:0] a11;
    logic signed [15:0] a12;
    logic signed [15:0] a20;
    logic signed [15:0] a21;
    logic signed [15:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               singular;
    logic               saturated;
  } out_t;

endpackage
`default_nettype wire

/* hdl/matrix3x3_inverse.sv */
// Fully pipelined 3x3 matrix inverse by the adjugate, Q8.8 in and Q16.16 out.
//
// One matrix request is taken every cycle and one result leaves every cycle
// while the output is not stalled. Four stages form the cofactors and the
// determinant, one stage sets up the nine divisions, 33 restoring divider
// stages produce one quotient bit each, and a last stage applies sign and
// saturation. Quotients truncate toward zero. A zero determinant gives all
// entries zero with singular set. Quotients outside Q16.16 clip and set
// saturated. A stalled output freezes the whole pipeline, nothing is lost.
`default_nettype none
module matrix3x3_inverse import mi3_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output       logic in_ready_o,
  input  wire  in_t  in_data_i,
  output       logic out_valid_o,
  input  wire  logic out_ready_i,
  output       out_t out_data_o
);

  localparam int unsigned DivBits = 33;
  localparam int unsigned NumW    = 56;
  localparam int unsigned DenW    = 48;
  localparam int unsigned WideW   = 82;
  localparam int unsigned Ent     = Dim * Dim;

  logic adv;
  logic signed [15:0] m [Dim][Dim];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  assign m[0][0] = in_data_i.a00;
  assign m[0][1] = in_data_i.a01;
  assign m[0][2] = in_data_i.a02;
  assign m[1][0] = in_data_i.a10;
  assign m[1][1] = in_data_i.a11;
  assign m[1][2] = in_data_i.a12;
  assign m[2][0] = in_data_i.a20;
  assign m[2][1] = in_data_i.a21;
  assign m[2][2] = in_data_i.a22;

  // Stage 1: the two products of every cofactor.
  logic v1_q;
  logic signed [31:0] pa_q [Dim][Dim];
  logic signed [31:0] pb_q [Dim][Dim];
  logic signed [15:0] a0_1_q [Dim];

  for (genvar i = 0; i < Dim; i++) begin : g_prod_r
    for (genvar j = 0; j < Dim; j++) begin : g_prod_c
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pa_q[i][j] <= m[(i+1)%Dim][(j+1)%Dim] * m[(i+2)%Dim][(j+2)%Dim];
          pb_q[i][j] <= m[(i+1)%Dim][(j+2)%Dim] * m[(i+2)%Dim][(j+1)%Dim];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < Dim; j++) begin
        a0_1_q[j] <= m[0][j];
      end
    end
  end

  // Stage 2: cofactors.
  logic v2_q;
  logic signed [32:0] cof2_q [Dim][Dim];
  logic signed [15:0] a0_2_q [Dim];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Dim; i++) begin
        for (int j = 0; j < Dim; j++) begin
          cof2_q[i][j] <= 33'(pa_q[i][j]) - 33'(pb_q[i][j]);
        end
        a0_2_q[i] <= a0_1_q[i];
      end
    end
  end

  // Stage 3: row 0 expansion terms of the determinant.
  logic v3_q;
  logic signed [32:0] cof3_q [Dim][Dim];
  logic signed [48:0] tp_q [Dim];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Dim; i++) begin
        for (int j = 0; j < Dim; j++) begin
          cof3_q[i][j] <= cof2_q[i][j];
        end
        tp_q[i] <= 49'(a0_2_q[i]) * 49'(cof2_q[0][i]);
      end
    end
  end

  // Stage 4: determinant.
  logic v4_q;
  logic signed [32:0] cof4_q [Dim][Dim];
  logic signed [49:0] det_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < Dim; i++) begin
        for (int j = 0; j < Dim; j++) begin
          cof4_q[i][j] <= cof3_q[i][j];
        end
      end
      det_q <= 50'(tp_q[0]) + 50'(tp_q[1]) + 50'(tp_q[2]);
    end
  end

  // Divider pipeline; index 0 is the setup stage, entry e is row e/3, col e%3.
  logic                vd_q   [DivBits+1];
  logic [DenW-1:0]     den_q  [DivBits+1];
  logic                sing_q [DivBits+1];
  logic [NumW-1:0]     rem_q  [DivBits+1][Ent];
  logic [DivBits-1:0]  quo_q  [DivBits+1][Ent];
  logic                neg_q  [DivBits+1][Ent];
  logic                ovf_q  [DivBits+1][Ent];

  logic [49:0] det_mag;
  logic [DenW-1:0] den_d;
  assign det_mag = det_q[49] ? 50'(-det_q) : 50'(det_q);
  assign den_d   = det_mag[DenW-1:0];

  for (genvar e = 0; e < Ent; e++) begin : g_setup
    logic signed [32:0] c;
    logic [32:0]        cmag;
    logic [NumW-1:0]    num;
    assign c    = cof4_q[e % Dim][e / Dim];
    assign cmag = c[32] ? 33'(-c) : 33'(c);
    assign num  = {cmag[31:0], 24'b0};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[0][e] <= num;
        quo_q[0][e] <= '0;
        neg_q[0][e] <= c[32] != det_q[49];
        ovf_q[0][e] <= {26'b0, num} >= ({34'b0, den_d} << DivBits);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q[0]  <= den_d;
      sing_q[0] <= det_q == '0;
    end
  end

  for (genvar s = 0; s < DivBits; s++) begin : g_div
    localparam int unsigned K = DivBits - 1 - s;
    logic [WideW-1:0] dsh;
    assign dsh = {34'b0, den_q[s]} << K;
    for (genvar e = 0; e < Ent; e++) begin : g_ent
      logic [WideW-1:0] rx;
      logic [WideW-1:0] diff;
      logic             take;
      assign rx   = {26'b0, rem_q[s][e]};
      assign diff = rx - dsh;
      assign take = rx >= dsh;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[s+1][e] <= take ? diff[NumW-1:0] : rem_q[s][e];
          quo_q[s+1][e] <= quo_q[s][e] | (take ? (DivBits'(1) << K) : '0);
          neg_q[s+1][e] <= neg_q[s][e];
          ovf_q[s+1][e] <= ovf_q[s][e];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q[s+1]  <= den_q[s];
        sing_q[s+1] <= sing_q[s];
      end
    end
  end

  // Sign and saturation.
  logic [31:0] res [Ent];
  logic [Ent-1:0] clip;

  always_comb begin
    for (int e = 0; e < Ent; e++) begin
      logic [DivBits-1:0] q;
      q = quo_q[DivBits][e];
      if (!neg_q[DivBits][e]) begin
        clip[e] = ovf_q[DivBits][e] || (q > 33'h07FFFFFFF);
        res[e]  = clip[e] ? 32'h7FFFFFFF : q[31:0];
      end else begin
        clip[e] = ovf_q[DivBits][e] || (q > 33'h080000000);
        res[e]  = clip[e] ? 32'h80000000 : 32'(-q[31:0]);
      end
      if (sing_q[DivBits]) begin
        clip[e] = 1'b0;
        res[e]  = '0;
      end
    end
  end

  out_t out_d;
  always_comb begin
    out_d.inv00     = res[0];
    out_d.inv01     = res[1];
    out_d.inv02     = res[2];
    out_d.inv10     = res[3];
    out_d.inv11     = res[4];
    out_d.inv12     = res[5];
    out_d.inv20     = res[6];
    out_d.inv21     = res[7];
    out_d.inv22     = res[8];
    out_d.singular  = sing_q[DivBits];
    out_d.saturated = |clip;
  end

  out_t out_q;
  logic out_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s <= DivBits; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      vd_q[0]     <= v4_q;
      for (int s = 0; s < DivBits; s++) begin
        vd_q[s+1] <= vd_q[s];
      end
      out_valid_q <= vd_q[DivBits];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_sing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      !out_data_o.saturated && out_data_o.inv00 == 0 && out_data_o.inv22 == 0)
    else $error("singular result carries data");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while output stalled");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vd_q[DivBits]) && $stable(v1_q))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
